// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the list RTL.
// Each check is sampled on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("list invariant violated");
// Property that must hold in the clock cycle after its trigger.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list update check failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/tkl_pkg.sv =====
// Types and request codes for the top-K largest size list.
// No dependencies; imported by the cell and the top level.
package tkl_pkg;

    localparam int SIZE_W     = 64;
    localparam int TAG_PORT_W = 32;
    localparam int INDEX_W    = 6;
    localparam int ECOUNT_W   = 7;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [TAG_PORT_W-1:0] tag;
        logic [SIZE_W-1:0]     size;
        logic [INDEX_W-1:0]    index;
    } t_req;

    typedef struct packed {
        logic                  status;
        logic [TAG_PORT_W-1:0] out_tag;
        logic [SIZE_W-1:0]     out_size;
        logic [ECOUNT_W-1:0]   entry_count;
    } t_rsp;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic ins_en;   // an insert is transferred this cycle
        logic clr;      // a clear is transferred this cycle
        logic app;      // the new record goes behind all valid entries
    } t_cell_ctl;

endpackage

// ===== hdl/tkl_cell.sv =====
// One list position: holds a (tag, size) record and a valid bit.
// Depends on tkl_pkg; instantiated once per position by the top level.
module tkl_cell import tkl_pkg::*; #(
    parameter int TAG_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [TAG_W-1:0]  i_tag,
    input  logic              i_prev_ins,
    input  logic              i_prev_valid,
    input  logic [SIZE_W-1:0] i_prev_size,
    input  logic [TAG_W-1:0]  i_prev_tag,
    output logic              o_ins,
    output logic              o_gt,
    output logic              o_valid,
    output logic [SIZE_W-1:0] o_size,
    output logic [TAG_W-1:0]  o_tag
);

    logic              r_valid;
    logic [SIZE_W-1:0] r_size;
    logic [TAG_W-1:0]  r_tag;
    logic              n_valid;
    logic [SIZE_W-1:0] n_size;
    logic [TAG_W-1:0]  n_tag;
    logic              w_ge;

    // Local compare of the incoming size against the stored one.
    assign w_ge = r_valid && (i_size >= r_size);
    assign o_gt = r_valid && (i_size > r_size);

    // This position changes on an insert when the new record lands here or above.
    // Empty positions exist only when the list is not full, and then an insert
    // always happens.
    assign o_ins = r_valid ? (w_ge && !i_ctl.app) : 1'b1;

    // Hold, take the neighbor's record, or load the new record.
    always_comb begin
        n_valid = r_valid;
        n_size  = r_size;
        n_tag   = r_tag;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
            n_size  = '0;
            n_tag   = '0;
        end else if (i_ctl.ins_en) begin
            if (i_prev_ins) begin
                n_valid = i_prev_valid;
                n_size  = i_prev_size;
                n_tag   = i_prev_tag;
            end else if (o_ins) begin
                n_valid = 1'b1;
                n_size  = i_size;
                n_tag   = i_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_size  <= '0;
            r_tag   <= '0;
        end else begin
            r_valid <= n_valid;
            r_size  <= n_size;
            r_tag   <= n_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_size  = r_size;
    assign o_tag   = r_tag;

endmodule

// ===== hdl/top_k_largest_size_list.sv =====
// Top level of the top-K largest size list: a row of tkl_cell positions,
// a count, read selection and a registered response. Depends on tkl_pkg
// and assert_macros.svh.
//
//  Channel   Handshake           Payload  Items
//  request   i_valid / o_ready   i_req    insert, read, clear
//  response  o_valid / i_ready   o_rsp    one per request
//
// Each request acts at the edge that transfers it: all positions compare
// the new size in parallel and shift by one place toward the tail in the
// same edge. A response is in the output register in the cycle after its
// request is transferred; a new request is taken while that register is
// free or being emptied: one request per cycle while i_ready stays high.
// Synchronous active-low reset empties the list and the output register.
`include "assert_macros.svh"
module top_k_largest_size_list import tkl_pkg::*; #(
    parameter int LIST_DEPTH = 20,
    parameter int TAG_BITS   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    logic                  w_in_fire;
    logic                  w_full;
    logic                  w_is_ins;
    logic                  w_is_read;
    logic                  w_is_clr;
    logic                  w_oor;
    t_cell_ctl             w_ctl;
    logic [TAG_W-1:0]      w_new_tag;
    logic [LIST_DEPTH-1:0] w_ins;
    logic [LIST_DEPTH-1:0] w_gt;
    logic [LIST_DEPTH-1:0] w_valid;
    logic [SIZE_W-1:0]     w_size [LIST_DEPTH];
    logic [TAG_W-1:0]      w_tag  [LIST_DEPTH];
    logic [SIZE_W-1:0]     w_rd_size;
    logic [TAG_W-1:0]      w_rd_tag;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;

    // Handshake: the output register parts the two sides.
    assign o_ready   = !r_out_valid || i_ready;
    assign w_in_fire = i_valid && o_ready;

    assign w_is_ins  = (i_req.req_type == REQ_INSERT);
    assign w_is_read = (i_req.req_type == REQ_READ);
    assign w_is_clr  = (i_req.req_type == REQ_CLEAR);
    assign w_full    = (r_count == CNT_W'(LIST_DEPTH));
    assign w_new_tag = TAG_W'(i_req.tag);

    // The record is appended when the list has room and beats no valid entry.
    assign w_ctl.ins_en = w_in_fire && w_is_ins;
    assign w_ctl.clr    = w_in_fire && w_is_clr;
    assign w_ctl.app    = !w_full && !(|w_gt);

    // Row of list positions, each fed by its upper neighbor.
    for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
        logic              w_prev_ins;
        logic              w_prev_valid;
        logic [SIZE_W-1:0] w_prev_size;
        logic [TAG_W-1:0]  w_prev_tag;

        if (j == 0) begin : g_head
            assign w_prev_ins   = 1'b0;
            assign w_prev_valid = 1'b0;
            assign w_prev_size  = '0;
            assign w_prev_tag   = '0;
        end else begin : g_link
            assign w_prev_ins   = w_ins[j-1];
            assign w_prev_valid = w_valid[j-1];
            assign w_prev_size  = w_size[j-1];
            assign w_prev_tag   = w_tag[j-1];
        end

        tkl_cell #(
            .TAG_W (TAG_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_size       (i_req.size),
            .i_tag        (w_new_tag),
            .i_prev_ins   (w_prev_ins),
            .i_prev_valid (w_prev_valid),
            .i_prev_size  (w_prev_size),
            .i_prev_tag   (w_prev_tag),
            .o_ins        (w_ins[j]),
            .o_gt         (w_gt[j]),
            .o_valid      (w_valid[j]),
            .o_size       (w_size[j]),
            .o_tag        (w_tag[j])
        );
    end

    // Read selection: each position matches its own index.
    always_comb begin
        w_rd_size = '0;
        w_rd_tag  = '0;
        for (int j = 0; j < LIST_DEPTH; j++) begin
            if (i_req.index == INDEX_W'(j)) begin
                w_rd_size = w_rd_size | w_size[j];
                w_rd_tag  = w_rd_tag | w_tag[j];
            end
        end
    end

    assign w_oor = (ECOUNT_W'(i_req.index) >= ECOUNT_W'(LIST_DEPTH));

    // Count after the request; it saturates at the list depth.
    always_comb begin
        n_count = r_count;
        if (w_is_ins && !w_full) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_is_clr) begin
            n_count = '0;
        end
    end

    // Response contents.
    always_comb begin
        n_rsp             = '0;
        n_rsp.entry_count = ECOUNT_W'(n_count);
        if (w_is_read) begin
            if (w_oor) begin
                n_rsp.status = 1'b1;
            end else begin
                n_rsp.out_size = w_rd_size;
                n_rsp.out_tag  = TAG_PORT_W'(w_rd_tag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_count <= n_count;
            end
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    // The count matches the valid positions, and these fill from the head.
    `ASSERT_ALWAYS(a_count_le_depth, r_count <= CNT_W'(LIST_DEPTH))
    `ASSERT_ALWAYS(a_count_matches, $countones(w_valid) == int'(r_count))
    `ASSERT_ALWAYS(a_valid_packed, ((w_valid >> 1) & ~w_valid) == '0)
    `ASSERT_NEXT(a_clear_empties, w_in_fire && w_is_clr, r_count == '0 && w_valid == '0)
    `ASSERT_NEXT(a_insert_grows, w_in_fire && w_is_ins && !w_full, r_count == $past(r_count) + CNT_W'(1))

endmodule
